// ===== sv/mcrb_pkg.sv =====
// Shared types and constants for the multichannel receive ring buffer.
package mcrb_pkg;

  localparam int CHANNELS  = 4;
  localparam int BUF_DEPTH = 64;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W   = $clog2(BUF_DEPTH);
  localparam int CNT_W   = $clog2(BUF_DEPTH + 1);
  localparam int MEM_D   = CHANNELS * BUF_DEPTH;
  localparam int ADDR_W  = (MEM_D > 1) ? $clog2(MEM_D) : 1;

  localparam int CMD_W   = 2;
  localparam int CHSEL_W = 2;
  localparam int BYTE_W  = 8;
  localparam int REQ_W   = 7;
  localparam int FILL_W  = 7;

  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 24;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIRST,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_byte;
  } ctrl_t;

  typedef struct packed {
    logic rd_start;
    logic more;
  } status_t;

endpackage

// ===== sv/multichannel_rx_ring_buffer.sv =====
// Top level of the multichannel receive ring buffer.
//
// One receive FIFO of BUF_DEPTH bytes per channel. Requests enter on the s_ side:
// push a byte, read up to read_request bytes, query fill count and overflow, or
// clear the overflow flag. Results leave on the m_ side, one per request, or one
// per byte for a read that delivers bytes, with m_tlast on the final one.
// Sequence: a request is taken in the idle state and executed in the cycle after, and
// its first result is then registered and shown in the output state, after a first-byte
// state for a read that delivers bytes, which waits on the registered store read.
// Further read bytes follow one per cycle while the receiver is ready; the
// controller handles one request at a time and s_tready is high only while no
// result is pending.
// Reset clears all pointers, counts and overflow flags; the byte store holds no
// reset value and is only read where written. When the receiver stalls, the
// result register holds its contents and no new request is taken.
module multichannel_rx_ring_buffer
  import mcrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // rx_byte, read_request, clear_mask
  input  logic [S_TDATA_W-1:0] s_tdata,
  // command, channel
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // data_byte, granted, fill_count, overflow, dropped
  output logic [M_TDATA_W-1:0] m_tdata,
  // data_valid
  output logic                 m_tuser,
  output logic                 m_tlast
);

  ctrl_t   ctrl;
  status_t stat;

  mcrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .ctrl     (ctrl)
  );

  mcrb_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .stat    (stat),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request taken while a result is pending");

  a_exec_gap: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !m_tvalid)
    else $error("result valid in the execute cycle");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("result without data is not marked last");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
    else $error("block not idle after final result");

endmodule

// ===== sv/mcrb_ctrl.sv =====
// Controller state machine: request intake, command execution and result sequencing.
module mcrb_ctrl
  import mcrb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    m_tready,
  input  status_t stat,
  output logic    s_tready,
  output logic    m_tvalid,
  output ctrl_t   ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = stat.rd_start ? ST_FIRST : ST_OUT;
      end
      ST_FIRST: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready && !stat.more) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    m_tvalid       = 1'b0;
    ctrl.capture   = 1'b0;
    ctrl.exec      = 1'b0;
    ctrl.load_byte = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready     = 1'b1;
        ctrl.capture = s_tvalid;
      end
      ST_EXEC: begin
        ctrl.exec = 1'b1;
      end
      ST_FIRST: begin
        ctrl.load_byte = 1'b1;
      end
      ST_OUT: begin
        m_tvalid       = 1'b1;
        ctrl.load_byte = m_tready && stat.more;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/mcrb_dp.sv =====
// Datapath: per-channel pointers, counts, flags, byte store and result register.
module mcrb_dp
  import mcrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_t                ctrl,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  output status_t              stat,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  // captured request
  logic [CMD_W-1:0]   cmd_q;
  logic [CHSEL_W-1:0] ch_q;
  logic [BYTE_W-1:0]  byte_q;
  logic [REQ_W-1:0]   req_q;
  logic               mask_q;

  // channel state
  logic [PTR_W-1:0] rp  [CHANNELS];
  logic [PTR_W-1:0] wp  [CHANNELS];
  logic [CNT_W-1:0] cnt [CHANNELS];
  logic             ovf [CHANNELS];
  logic [CNT_W-1:0] left;

  logic [BYTE_W-1:0] mem [MEM_D];
  logic [BYTE_W-1:0] rdata;

  // result register
  logic [BYTE_W-1:0] out_data;
  logic              out_dvalid;
  logic              out_last;
  logic [FILL_W-1:0] out_granted;
  logic [FILL_W-1:0] out_fill;
  logic              out_ovf;
  logic              out_drop;

  logic             ch_ok;
  logic [CH_W-1:0]  ch_idx;
  logic [CNT_W-1:0] cur_cnt;
  logic [CNT_W-1:0] grant;
  logic [PTR_W-1:0] cur_rp;
  logic [PTR_W-1:0] cur_wp;
  logic [PTR_W-1:0] rp_inc;
  logic [PTR_W-1:0] wp_inc;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] ch_base;

  assign ch_ok   = int'(ch_q) < CHANNELS;
  assign ch_idx  = CH_W'(ch_q);
  assign cur_cnt = cnt[ch_idx];
  assign cur_rp  = rp[ch_idx];
  assign cur_wp  = wp[ch_idx];
  assign rp_inc  = (int'(cur_rp) == BUF_DEPTH - 1) ? '0 : cur_rp + PTR_W'(1);
  assign wp_inc  = (int'(cur_wp) == BUF_DEPTH - 1) ? '0 : cur_wp + PTR_W'(1);
  assign grant   = (req_q > REQ_W'(cur_cnt)) ? cur_cnt : CNT_W'(req_q);
  assign ch_base = ADDR_W'(ch_idx) * ADDR_W'(BUF_DEPTH);
  assign rd_addr = ch_base + ADDR_W'(cur_rp);
  assign wr_addr = ch_base + ADDR_W'(cur_wp);

  assign stat.rd_start = ch_ok && (cmd_q == CMD_READ) && (grant != '0);
  assign stat.more     = (left != '0);

  assign rd_en = (ctrl.exec && stat.rd_start) ||
                 (ctrl.load_byte && (left > CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q  <= s_tuser[CMD_W-1:0];
      ch_q   <= s_tuser[CMD_W +: CHSEL_W];
      byte_q <= s_tdata[BYTE_W-1:0];
      req_q  <= s_tdata[BYTE_W +: REQ_W];
      mask_q <= s_tdata[BYTE_W + REQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && ch_ok && (cmd_q == CMD_PUSH) && (int'(cur_cnt) < BUF_DEPTH)) begin
      mem[wr_addr] <= byte_q;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rp[i]  <= '0;
        wp[i]  <= '0;
        cnt[i] <= '0;
        ovf[i] <= 1'b0;
      end
      left <= '0;
    end else if (ctrl.exec && ch_ok) begin
      unique case (cmd_q)
        CMD_PUSH: begin
          if (int'(cur_cnt) < BUF_DEPTH) begin
            wp[ch_idx]  <= wp_inc;
            cnt[ch_idx] <= cur_cnt + CNT_W'(1);
          end else begin
            ovf[ch_idx] <= 1'b1;
          end
        end
        CMD_READ: begin
          if (grant != '0) begin
            cnt[ch_idx] <= cur_cnt - grant;
            rp[ch_idx]  <= rp_inc;
            left        <= grant;
          end
        end
        CMD_CLEAR: begin
          if (mask_q) ovf[ch_idx] <= 1'b0;
        end
        CMD_QUERY: ;
        default: ;
      endcase
    end else if (ctrl.load_byte) begin
      left <= left - CNT_W'(1);
      if (left > CNT_W'(1)) rp[ch_idx] <= rp_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      out_data    <= '0;
      out_dvalid  <= 1'b0;
      out_last    <= 1'b1;
      out_granted <= '0;
      out_drop    <= 1'b0;
      out_fill    <= FILL_W'(cur_cnt);
      out_ovf     <= ovf[ch_idx];
      if (!ch_ok) begin
        out_fill <= '0;
        out_ovf  <= 1'b0;
      end else begin
        unique case (cmd_q)
          CMD_PUSH: begin
            if (int'(cur_cnt) < BUF_DEPTH) begin
              out_fill <= FILL_W'(cur_cnt + CNT_W'(1));
            end else begin
              out_ovf  <= 1'b1;
              out_drop <= 1'b1;
            end
          end
          CMD_READ: begin
            if (grant != '0) begin
              out_granted <= FILL_W'(grant);
              out_fill    <= FILL_W'(cur_cnt - grant);
            end
          end
          CMD_CLEAR: begin
            if (mask_q) out_ovf <= 1'b0;
          end
          CMD_QUERY: ;
          default: ;
        endcase
      end
    end else if (ctrl.load_byte) begin
      out_data   <= rdata;
      out_dvalid <= 1'b1;
      out_last   <= (left == CNT_W'(1));
    end
  end

  assign m_tdata = {out_drop, out_ovf, out_fill, out_granted, out_data};
  assign m_tuser = out_dvalid;
  assign m_tlast = out_last;

endmodule

// ===== sim/tb_multichannel_rx_ring_buffer.sv =====
// Self-checking testbench for the multichannel receive ring buffer.
`timescale 1ns / 1ps

module tb_multichannel_rx_ring_buffer
  import mcrb_pkg::*;
();

  localparam int RUN_LIMIT = 1_000_000;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              last;
    logic [REQ_W-1:0]  granted;
    logic [FILL_W-1:0] fill_count;
    logic              overflow;
    logic              dropped;
  } rx_result_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;

  // predicted channel state
  logic [BYTE_W-1:0] ring_mem [CHANNELS][BUF_DEPTH];
  logic [PTR_W-1:0]  rd_ptr [CHANNELS];
  logic [PTR_W-1:0]  wr_ptr [CHANNELS];
  int unsigned       held_bytes [CHANNELS];
  logic              ovf_flag [CHANNELS];

  rx_result_t  pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  multichannel_rx_ring_buffer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic predict_results(input logic [CMD_W-1:0] cmd, input logic [CHSEL_W-1:0] ch,
                                 input logic [BYTE_W-1:0] rx_byte,
                                 input logic [REQ_W-1:0] req, input logic mask);
    rx_result_t  r;
    int unsigned grant;
    bit          delivered;
    r = '0;
    r.last = 1'b1;
    delivered = 1'b0;
    if (ch >= CHANNELS) begin
      pending_results.push_back(r);
      return;
    end
    case (cmd)
      CMD_PUSH: begin
        if (held_bytes[ch] < BUF_DEPTH) begin
          ring_mem[ch][wr_ptr[ch]] = rx_byte;
          wr_ptr[ch] = (int'(wr_ptr[ch]) == BUF_DEPTH - 1) ? '0 : wr_ptr[ch] + PTR_W'(1);
          held_bytes[ch]++;
        end else begin
          ovf_flag[ch] = 1'b1;
          r.dropped = 1'b1;
        end
      end
      CMD_READ: begin
        grant = (32'(req) > held_bytes[ch]) ? held_bytes[ch] : 32'(req);
        if (grant != 0) begin
          held_bytes[ch] -= grant;
          for (int unsigned i = 0; i < grant; i++) begin
            r.data_byte  = ring_mem[ch][rd_ptr[ch]];
            r.data_valid = 1'b1;
            r.last       = (i + 1 == grant);
            r.granted    = REQ_W'(grant);
            r.fill_count = FILL_W'(held_bytes[ch]);
            r.overflow   = ovf_flag[ch];
            rd_ptr[ch] = (int'(rd_ptr[ch]) == BUF_DEPTH - 1) ? '0 : rd_ptr[ch] + PTR_W'(1);
            pending_results.push_back(r);
          end
          delivered = 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (mask) ovf_flag[ch] = 1'b0;
      end
      default: ;
    endcase
    if (!delivered) begin
      r.fill_count = FILL_W'(held_bytes[ch]);
      r.overflow   = ovf_flag[ch];
      pending_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    rx_result_t got;
    rx_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.data_byte  = m_tdata[7:0];
      got.granted    = m_tdata[14:8];
      got.fill_count = m_tdata[21:15];
      got.overflow   = m_tdata[22];
      got.dropped    = m_tdata[23];
      got.data_valid = m_tuser;
      got.last       = m_tlast;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result: %p", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        if (got.data_byte != want.data_byte || got.data_valid != want.data_valid ||
            got.last != want.last || got.granted != want.granted ||
            got.fill_count != want.fill_count || got.overflow != want.overflow ||
            got.dropped != want.dropped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] result mismatch: expected %p, actual %p", $realtime, want, got);
        end
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CHSEL_W-1:0] ch,
                              input logic [BYTE_W-1:0] rx_byte,
                              input logic [REQ_W-1:0] req, input logic mask);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {mask, req, rx_byte};
    s_tuser  <= {ch, cmd};
    do @(posedge clk); while (!s_tready);
    predict_results(cmd, ch, rx_byte, req, mask);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(CMD_PUSH, 2'd0, 8'h00, 7'h7F, 1'b1);
    send_request(CMD_PUSH, 2'd0, 8'hFF, 7'h00, 1'b0);
    send_request(CMD_PUSH, 2'd0, 8'h5A, 7'h40, 1'b1);
    send_request(CMD_QUERY, 2'd0, 8'hFF, 7'h7F, 1'b1);
    send_request(CMD_READ, 2'd0, 8'hFF, 7'd0, 1'b1);
    send_request(CMD_READ, 2'd1, 8'h00, 7'd127, 1'b0);
    send_request(CMD_READ, 2'd0, 8'h00, 7'd1, 1'b0);
    send_request(CMD_READ, 2'd0, 8'hFF, 7'd127, 1'b1);
    send_request(CMD_READ, 2'd0, 8'h00, 7'd64, 1'b0);
    send_request(CMD_CLEAR, 2'd3, 8'hFF, 7'h7F, 1'b0);
    send_request(CMD_CLEAR, 2'd3, 8'h00, 7'h00, 1'b1);
    send_request(CMD_QUERY, 2'd3, 8'h00, 7'h00, 1'b0);
    send_request(CMD_PUSH, 2'd3, 8'hA5, 7'h00, 1'b0);
    send_request(CMD_PUSH, 2'd1, 8'h3C, 7'h00, 1'b0);
    send_request(CMD_PUSH, 2'd2, 8'hC3, 7'h00, 1'b0);
    send_request(CMD_READ, 2'd3, 8'h00, 7'd64, 1'b0);
    send_request(CMD_READ, 2'd1, 8'h00, 7'd1, 1'b0);
    send_request(CMD_READ, 2'd2, 8'h00, 7'd2, 1'b0);
    send_request(CMD_QUERY, 2'd2, 8'h00, 7'h00, 1'b0);
    wait_for_drain();
  endtask

  // fill to the top, overflow, drop, wrap both pointers, then clear the flag
  task automatic test_full_channel(input logic [CHSEL_W-1:0] ch);
    for (int i = 0; i < BUF_DEPTH + 2; i++)
      send_request(CMD_PUSH, ch, BYTE_W'($urandom_range(255)), REQ_W'($urandom_range(127)),
                   1'($urandom_range(1)));
    send_request(CMD_QUERY, ch, 8'h00, 7'h00, 1'b0);
    send_request(CMD_READ, ch, 8'h00, 7'd30, 1'b0);
    for (int i = 0; i < 10; i++)
      send_request(CMD_PUSH, ch, BYTE_W'($urandom_range(255)), 7'h00, 1'b0);
    send_request(CMD_READ, ch, 8'h00, 7'd127, 1'b0);
    send_request(CMD_CLEAR, ch, 8'h00, 7'h00, 1'b0);
    send_request(CMD_CLEAR, ch, 8'h00, 7'h00, 1'b1);
    send_request(CMD_QUERY, ch, 8'h00, 7'h00, 1'b0);
    wait_for_drain();
  endtask

  task automatic test_random_mix(input int unsigned n_items);
    int unsigned        pick;
    logic [CMD_W-1:0]   cmd;
    logic [REQ_W-1:0]   req;
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) cmd = CMD_PUSH;
      else if (pick < 80) cmd = CMD_READ;
      else if (pick < 90) cmd = CMD_QUERY;
      else cmd = CMD_CLEAR;
      pick = $urandom_range(99);
      if (pick < 70) req = REQ_W'($urandom_range(20));
      else if (pick < 90) req = REQ_W'($urandom_range(64));
      else req = REQ_W'($urandom_range(127));
      send_request(cmd, CHSEL_W'($urandom_range(CHANNELS - 1)), BYTE_W'($urandom_range(255)),
                   req, 1'($urandom_range(1)));
    end
    wait_for_drain();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      rd_ptr[c]     = '0;
      wr_ptr[c]     = '0;
      held_bytes[c] = 0;
      ovf_flag[c]   = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_channel(2'd2);

    send_idle_pct  = 21;
    recv_stall_pct = 21;
    test_full_channel(2'd1);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_mix(25);
    send_idle_pct  = 49;
    test_random_mix(25);
    send_idle_pct  = 0;
    recv_stall_pct = 49;
    test_random_mix(25);
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    test_random_mix(25);

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
